// File: hdl/f2p_pkg.sv
// shared types and constants for the float to pcm16 packetizer
// no dependencies; imported by f2p_quant and float_to_pcm16_packetizer
package f2p_pkg;

  localparam int unsigned PCM_W   = 16;
  localparam int unsigned FLOAT_W = 32;
  localparam int unsigned START_W = 48;
  localparam int unsigned DUR_W   = 16;

  // configuration register indexes
  localparam logic CFG_CHANNEL_COUNT     = 1'b0;
  localparam logic CFG_FRAMES_PER_PACKET = 1'b1;

  // input beat kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic [7:0] EXP_ONE = 8'd127;
  localparam logic [7:0] EXP_MAX = 8'hFF;

  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
  localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sh8000;

  localparam logic [3:0]  CH_MAX      = 4'd8;
  localparam logic [3:0]  CC_RESET    = 4'd1;
  localparam logic [15:0] FPP_RESET   = 16'd1024;
  localparam logic [14:0] SCALE_POS   = 15'd32767;

  typedef struct packed {
    logic                    flush;
    logic                    eop;
    logic [DUR_W-1:0]        dur;
    logic [START_W-1:0]      start;
    logic signed [PCM_W-1:0] pcm;
  } f2p_res_t;

endpackage

// File: hdl/f2p_quant.sv
// float32 to signed pcm16 quantizer, purely combinational
// depends on f2p_pkg
module f2p_quant (
  input  logic [f2p_pkg::FLOAT_W-1:0]      sample_bits,
  output logic signed [f2p_pkg::PCM_W-1:0] pcm
);
  import f2p_pkg::*;

  logic        sgn;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [38:0] prod;
  logic [23:0] keep;
  logic        grd;
  logic        stk;
  logic [24:0] mr;
  logic        wide;
  logic [8:0]  sh;
  logic [25:0] twice;
  logic [25:0] q;

  assign sgn  = sample_bits[31];
  assign expo = sample_bits[30:23];
  assign frac = sample_bits[22:0];
  assign mant = {1'b1, frac};
  // positive side scales by 32767 and rounds back to a float significand
  assign prod = 39'(mant) * 39'(SCALE_POS);
  assign wide = prod[38];

  always_comb begin
    if (wide) begin
      keep = prod[38:15];
      grd  = prod[14];
      stk  = |prod[13:0];
    end else begin
      keep = prod[37:14];
      grd  = prod[13];
      stk  = |prod[12:0];
    end
    mr = 25'(keep) + 25'(grd & (stk | keep[0]));
    // magnitude = significand * 2^-sh, rounded half up
    if (sgn) begin
      sh    = 9'd135 - 9'(expo);
      twice = {1'b0, mant, 1'b0} >> sh;
    end else begin
      sh    = 9'd136 - 9'(expo) - 9'(wide);
      twice = {mr, 1'b0} >> sh;
    end
    q = (twice + 26'd1) >> 1;

    if (expo == EXP_MAX && frac != '0) begin
      pcm = '0;
    end else if (expo >= EXP_ONE) begin
      pcm = sgn ? PCM_MIN : PCM_MAX;
    end else if (expo == '0) begin
      pcm = '0;
    end else if (sgn) begin
      pcm = PCM_W'(-$signed({1'b0, q[15:0]}));
    end else begin
      pcm = PCM_W'(q[15:0]);
    end
  end

endmodule

// File: hdl/float_to_pcm16_packetizer.sv
// float32 to pcm16 converter with frame based packet marking
// depends on f2p_pkg and f2p_quant
//
//  channel | dir | tdata (lsb up)                          | tuser        | tlast
//  in_     | in  | sample_bits[31:0]                       | command      | -
//  out_    | out | pcm_sample, packet_start_frame, frames  | flush_marker | end_of_packet
//  cfg_    | in  | index 0 channel_count, 1 frames_per_packet (write only)
//
// one beat per cycle while out_tready holds high; each beat passes the input register, then the result register
// the quantizer multiply and shift sit between those two registers
// rst_n is synchronous; it clears the valids, counters and config to defaults
// in_tready stays high while the input register is empty, or the result register can drain or is empty
// a flush with nothing pending is consumed without a result
module float_to_pcm16_packetizer #(
  parameter int unsigned FRAME_COUNTER_BITS = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_bits
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // pcm_sample, packet_start_frame, packet_frames
  output logic        out_tuser,  // flush_marker
  output logic        out_tlast,  // end_of_packet
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import f2p_pkg::*;

  localparam int unsigned EXT_W = (FRAME_COUNTER_BITS > START_W) ? FRAME_COUNTER_BITS : START_W;

  logic [3:0]  cc_r;
  logic [15:0] fpp_r;
  logic        s1_v_r;
  logic        s1_cmd_r;
  logic [31:0] s1_bits_r;
  logic        out_v_r;
  f2p_res_t    res_r;
  f2p_res_t    res_nxt;
  logic        emit;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] fip_r, fip_nxt;
  logic [FRAME_COUNTER_BITS-1:0] npf_r, npf_nxt;
  logic        advance;
  logic [3:0]  eff_cc;
  logic [15:0] eff_fpp;
  logic [16:0] count;
  logic signed [PCM_W-1:0] pcm;
  logic [EXT_W-1:0] start_ext;

  f2p_quant u_quant (
    .sample_bits (s1_bits_r),
    .pcm         (pcm)
  );

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || advance;

  assign eff_cc    = (cc_r == '0) ? 4'd1 : ((cc_r > CH_MAX) ? CH_MAX : cc_r);
  assign eff_fpp   = (fpp_r == '0) ? 16'd1 : fpp_r;
  assign count     = 17'(fip_r) + 17'd1;
  assign start_ext = EXT_W'(npf_r);

  always_comb begin
    pos_nxt       = pos_r;
    fip_nxt       = fip_r;
    npf_nxt       = npf_r;
    emit          = 1'b1;
    res_nxt.flush = 1'b0;
    res_nxt.eop   = 1'b0;
    res_nxt.dur   = '0;
    res_nxt.start = start_ext[START_W-1:0];
    res_nxt.pcm   = pcm;
    if (s1_cmd_r == CMD_FLUSH) begin
      res_nxt.flush = 1'b1;
      res_nxt.eop   = 1'b1;
      res_nxt.dur   = fip_r;
      res_nxt.pcm   = '0;
      emit          = (fip_r != '0) || (pos_r != '0);
      if (emit) begin
        npf_nxt = npf_r + FRAME_COUNTER_BITS'(fip_r);
        fip_nxt = '0;
      end
    end else if (4'(pos_r) + 4'd1 >= eff_cc) begin
      pos_nxt = '0;
      if (count >= 17'(eff_fpp)) begin
        res_nxt.eop = 1'b1;
        res_nxt.dur = count[15:0];
        npf_nxt     = npf_r + FRAME_COUNTER_BITS'(count);
        fip_nxt     = '0;
      end else begin
        fip_nxt = count[15:0];
      end
    end else begin
      pos_nxt = pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r     <= CC_RESET;
      fpp_r    <= FPP_RESET;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pos_r    <= '0;
      fip_r    <= '0;
      npf_r    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CHANNEL_COUNT) cc_r <= cfg_wdata[3:0];
        else                                fpp_r <= cfg_wdata;
      end
      if (in_tready) s1_v_r <= in_tvalid;
      if (advance) begin
        out_v_r <= s1_v_r && emit;
        if (s1_v_r) begin
          pos_r <= pos_nxt;
          fip_r <= fip_nxt;
          npf_r <= npf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_bits_r <= in_tdata;
    end
    if (advance && s1_v_r) res_r <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {res_r.dur, res_r.start, res_r.pcm};
  assign out_tuser  = res_r.flush;
  assign out_tlast  = res_r.eop;

  a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && res_r.pcm == '0)
    else $error("flush marker carries a sample");
  a_dur_only_eop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> res_r.dur == '0)
    else $error("duration without end of packet");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    4'(pos_r) < CH_MAX)
    else $error("channel position out of range");
  a_start_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance && s1_v_r) |-> $stable(npf_r))
    else $error("frame counter moved without a beat");

endmodule
